FILE: rtl/rvau_pkg.sv
// Shared types, constants and helper functions of the axis-angle rotation unit.
// No dependencies; imported by the CORDIC cell, the combine stage, the top level and the bench.
package rvau_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_N     = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
  localparam int SQRT_CELLS   = 32;
  localparam int DIV_CELLS    = 31;
  localparam int CW           = 34;
  localparam int RW           = 80;

  typedef logic signed [31:0]   word_t;
  typedef logic signed [CW-1:0] cord_t;
  typedef logic signed [RW-1:0] wide_t;

  localparam cord_t INV_GAIN = 34'sh26DD3B6A;
  localparam cord_t ONE_Q30  = 34'sh40000000;
  localparam logic signed [34:0] TWO_PI_Q30 = 35'sd6746518852;

  typedef struct packed {
    word_t [2:0]       vec;
    logic [15:0]       tang;
    logic              zero;
    logic [2:0]        sgn;
    logic [2:0][31:0]  anrm;
    word_t [2:0]       k;
    logic [1:0]        quad;
  } side_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Shift right by n, rounding half away from zero.
  function automatic wide_t rshr(input wide_t v, input logic [6:0] n);
    wide_t h;
    h = wide_t'(1) <<< (n - 7'd1);
    if (v[RW-1]) begin
      return -((-v + h) >>> n);
    end
    return (v + h) >>> n;
  endfunction

endpackage

FILE: rtl/rvau_sqrt_cell.sv
// One digit step of the pipelined integer square root.
// Standalone cell; the top level chains thirty-two of them.
module rvau_sqrt_cell (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [33:0] rem_i,
  input  logic [31:0] root_i,
  input  logic [63:0] rad_i,
  output logic [33:0] rem_o,
  output logic [31:0] root_o,
  output logic [63:0] rad_o
);

  logic [35:0] acc;
  logic [35:0] trial;
  logic        fit;

  always_comb begin
    acc   = {rem_i, rad_i[63:62]};
    trial = {2'b00, root_i, 2'b01};
    fit   = (acc >= trial);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= fit ? 34'(acc - trial) : acc[33:0];
      root_o <= {root_i[30:0], fit};
      rad_o  <= {rad_i[61:0], 2'b00};
    end
  end

endmodule

FILE: rtl/rvau_div_cell.sv
// One quotient bit of the three-lane restoring divider that normalizes the axis.
// Standalone cell; the top level chains thirty-one of them.
module rvau_div_cell (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [31:0]      mag_i,
  input  logic [2:0][31:0] rem_i,
  input  logic [2:0][30:0] low_i,
  input  logic [2:0][30:0] quo_i,
  output logic [31:0]      mag_o,
  output logic [2:0][31:0] rem_o,
  output logic [2:0][30:0] low_o,
  output logic [2:0][30:0] quo_o
);

  logic [2:0][32:0] tv;
  logic [2:0]       ge;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      tv[l] = {rem_i[l], low_i[l][30]};
      ge[l] = (tv[l] >= {1'b0, mag_i});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_o <= mag_i;
      for (int l = 0; l < 3; l++) begin
        rem_o[l] <= ge[l] ? 32'(tv[l] - {1'b0, mag_i}) : tv[l][31:0];
        low_o[l] <= {low_i[l][29:0], 1'b0};
        quo_o[l] <= {quo_i[l][29:0], ge[l]};
      end
    end
  end

endmodule

FILE: rtl/rvau_cordic_cell.sv
// One rotation-mode CORDIC iteration for the sine and cosine of the angle.
// Depends on rvau_pkg for the arctangent table and the datapath types.
module rvau_cordic_cell import rvau_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [4:0] step_i,
  input  cord_t      x_i,
  input  cord_t      y_i,
  input  cord_t      z_i,
  output cord_t      x_o,
  output cord_t      y_o,
  output cord_t      z_o
);

  cord_t xs;
  cord_t ys;
  cord_t at;

  always_comb begin
    xs = x_i >>> step_i;
    ys = y_i >>> step_i;
    at = {2'b00, atan_q30(step_i)};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!z_i[CW-1]) begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        z_o <= z_i - at;
      end else begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        z_o <= z_i + at;
      end
    end
  end

endmodule

FILE: rtl/rvau_combine.sv
// Seven-stage back end: dot and cross products, the three rotation terms and saturation.
// Depends on rvau_pkg for types and the rounding shift.
module rvau_combine import rvau_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  word_t [2:0] k_i,
  input  word_t [2:0] vec_i,
  input  word_t       cos_i,
  input  word_t       sin_i,
  input  logic        zero_i,
  output word_t [2:0] out_o,
  output logic        zero_o,
  output logic        sat_o
);

  word_t kk [3];
  word_t vv [3];

  logic signed [63:0] kv_q [3][3];
  logic signed [63:0] vc_q [3];
  word_t              c1_q, s1_q;
  word_t              k1_q [3];
  logic               z1_q;

  logic signed [35:0] p_q;
  logic signed [35:0] cr_q [3];
  logic signed [33:0] vct2_q [3];
  cord_t              omc_q;
  word_t              s2_q;
  word_t              k2_q [3];
  logic               z2_q;

  logic signed [71:0] pcr_q;
  logic signed [71:0] crs_q [3];
  logic signed [33:0] vct3_q [3];
  word_t              k3_q [3];
  logic               z3_q;

  logic signed [39:0] pc_q;
  logic signed [39:0] crt4_q [3];
  logic signed [33:0] vct4_q [3];
  word_t              k4_q [3];
  logic               z4_q;

  logic signed [71:0] kpc_q [3];
  logic signed [39:0] crt5_q [3];
  logic signed [33:0] vct5_q [3];
  logic               z5_q;

  logic signed [39:0] kpt_q [3];
  logic signed [39:0] crt6_q [3];
  logic signed [33:0] vct6_q [3];
  logic               z6_q;

  logic signed [41:0] sum [3];
  word_t              res [3];
  logic               sat;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      kk[l] = k_i[l];
      vv[l] = vec_i[l];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          kv_q[i][j] <= kk[i] * vv[j];
        end
        vc_q[i] <= vv[i] * cos_i;
        k1_q[i] <= kk[i];
      end
      c1_q <= cos_i;
      s1_q <= sin_i;
      z1_q <= zero_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= 36'(rshr(wide_t'(kv_q[0][0]) + wide_t'(kv_q[1][1]) + wide_t'(kv_q[2][2]),
                      7'd30));
      cr_q[0] <= 36'(rshr(wide_t'(kv_q[1][2]) - wide_t'(kv_q[2][1]), 7'd30));
      cr_q[1] <= 36'(rshr(wide_t'(kv_q[2][0]) - wide_t'(kv_q[0][2]), 7'd30));
      cr_q[2] <= 36'(rshr(wide_t'(kv_q[0][1]) - wide_t'(kv_q[1][0]), 7'd30));
      for (int i = 0; i < 3; i++) begin
        vct2_q[i] <= 34'(rshr(wide_t'(vc_q[i]), 7'd30));
        k2_q[i]   <= k1_q[i];
      end
      omc_q <= ONE_Q30 - cord_t'(c1_q);
      s2_q  <= s1_q;
      z2_q  <= z1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pcr_q <= p_q * omc_q;
      for (int i = 0; i < 3; i++) begin
        crs_q[i]  <= cr_q[i] * s2_q;
        vct3_q[i] <= vct2_q[i];
        k3_q[i]   <= k2_q[i];
      end
      z3_q <= z2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc_q <= 40'(rshr(wide_t'(pcr_q), 7'd30));
      for (int i = 0; i < 3; i++) begin
        crt4_q[i] <= 40'(rshr(wide_t'(crs_q[i]), 7'd30));
        vct4_q[i] <= vct3_q[i];
        k4_q[i]   <= k3_q[i];
      end
      z4_q <= z3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        kpc_q[i]  <= k4_q[i] * pc_q;
        crt5_q[i] <= crt4_q[i];
        vct5_q[i] <= vct4_q[i];
      end
      z5_q <= z4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        kpt_q[i]  <= 40'(rshr(wide_t'(kpc_q[i]), 7'd30));
        crt6_q[i] <= crt5_q[i];
        vct6_q[i] <= vct5_q[i];
      end
      z6_q <= z5_q;
    end
  end

  always_comb begin
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sum[i] = 42'(vct6_q[i]) + 42'(crt6_q[i]) + 42'(kpt_q[i]);
      if (sum[i] > 42'sd2147483647) begin
        res[i] = 32'sh7FFFFFFF;
        sat    = 1'b1;
      end else if (sum[i] < -42'sd2147483648) begin
        res[i] = 32'sh80000000;
        sat    = 1'b1;
      end else begin
        res[i] = 32'(sum[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        out_o[i] <= z6_q ? '0 : res[i];
      end
      zero_o <= z6_q;
      sat_o  <= z6_q ? 1'b0 : sat;
    end
  end

endmodule

FILE: rtl/rotate_vector_about_axis_unit.sv
// Rotation of a vector about an arbitrary axis, one request per cycle when the sink keeps up.
// The depth is set by the 32-cell square root chain, the 31-cell divider chain and the CORDIC.
// The whole chain advances together and halts only while a result waits at the output.
// Reset clears the valid flags only; datapath registers are not reset.
// Depends on rvau_pkg, rvau_sqrt_cell, rvau_div_cell, rvau_cordic_cell and rvau_combine.
module rotate_vector_about_axis_unit import rvau_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle
  input  logic [207:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z
  output logic [95:0]  m_axis_tdata,
  // zero_axis, saturated
  output logic [1:0]   m_axis_tuser
);

  localparam int ST_SQ_IN   = 5;
  localparam int ST_D0      = ST_SQ_IN + SQRT_CELLS + 1;
  localparam int ST_K       = ST_D0 + DIV_CELLS + 1;
  localparam int ST_B1      = ST_K + CORDIC_N + 1;
  localparam int PIPE_DEPTH = ST_B1 + 8;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q;

  side_t side_q [0:ST_B1];
  side_t side0;
  word_t axis0_q [3];
  logic [2:0][31:0] abs0;

  logic [31:0] or1;
  logic [4:0]  sh_d, sh2_q;
  logic [63:0] sq4_q [3];
  logic [63:0] m2_q;

  logic [33:0] srem  [0:SQRT_CELLS];
  logic [31:0] sroot [0:SQRT_CELLS];
  logic [63:0] srad  [0:SQRT_CELLS];

  logic [61:0]      num [3];
  logic [31:0]      dmag [0:DIV_CELLS];
  logic [2:0][31:0] drem [0:DIV_CELLS];
  logic [2:0][30:0] dlow [0:DIV_CELLS];
  logic [2:0][30:0] dquo [0:DIV_CELLS];
  logic [31:0]      mag0_q;
  logic [2:0][31:0] rem0_q;
  logic [2:0][30:0] low0_q;

  word_t [2:0]        kval;
  logic [16:0]        tsum;
  logic [1:0]         quad;
  logic signed [15:0] dang;
  logic signed [50:0] zprod;
  cord_t              z70_q;

  cord_t cx [0:CORDIC_N];
  cord_t cy [0:CORDIC_N];
  cord_t cz [0:CORDIC_N];

  cord_t cr_c, cr_s;
  word_t c_q, s_q;

  word_t [2:0] res;
  logic        res_zero, res_sat;

  function automatic word_t clamp_q30(input cord_t v);
    if (v > ONE_Q30) begin
      return 32'sh40000000;
    end
    if (v < -ONE_Q30) begin
      return -32'sh40000000;
    end
    return 32'(v);
  endfunction

  assign en            = ~vld_q[PIPE_DEPTH-1] | m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  always_comb begin
    side0        = '0;
    side0.vec[0] = s_axis_tdata[31:0];
    side0.vec[1] = s_axis_tdata[63:32];
    side0.vec[2] = s_axis_tdata[95:64];
    side0.tang   = s_axis_tdata[207:192];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0]  <= side0;
      axis0_q[0] <= s_axis_tdata[127:96];
      axis0_q[1] <= s_axis_tdata[159:128];
      axis0_q[2] <= s_axis_tdata[191:160];
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      abs0[l] = axis0_q[l][31] ? 32'(-axis0_q[l]) : axis0_q[l];
    end
  end

  always_comb begin
    or1  = side_q[1].anrm[0] | side_q[1].anrm[1] | side_q[1].anrm[2];
    sh_d = '0;
    for (int b = 0; b < 32; b++) begin
      if (or1[b]) begin
        sh_d = (b >= 30) ? 5'd0 : 5'(30 - b);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sh2_q <= sh_d;
      for (int l = 0; l < 3; l++) begin
        sq4_q[l] <= side_q[3].anrm[l] * side_q[3].anrm[l];
      end
      m2_q <= sq4_q[0] + sq4_q[1] + sq4_q[2];
    end
  end

  for (genvar g = 1; g <= ST_B1; g++) begin : g_side
    side_t nxt;
    if (g == 1) begin : g_sign
      always_comb begin
        nxt      = side_q[g-1];
        nxt.zero = (axis0_q[0] == '0) && (axis0_q[1] == '0) && (axis0_q[2] == '0);
        nxt.sgn  = {axis0_q[2][31], axis0_q[1][31], axis0_q[0][31]};
        nxt.anrm = abs0;
      end
    end else if (g == 3) begin : g_norm
      always_comb begin
        nxt = side_q[g-1];
        for (int l = 0; l < 3; l++) begin
          nxt.anrm[l] = side_q[g-1].anrm[l] << sh2_q;
        end
      end
    end else if (g == ST_K) begin : g_unit
      always_comb begin
        nxt      = side_q[g-1];
        nxt.k    = kval;
        nxt.quad = quad;
      end
    end else begin : g_pass
      always_comb begin
        nxt = side_q[g-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[g] <= nxt;
      end
    end
  end

  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign srad[0]  = m2_q;

  for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
    rvau_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (srem[j]),
      .root_i (sroot[j]),
      .rad_i  (srad[j]),
      .rem_o  (srem[j+1]),
      .root_o (sroot[j+1]),
      .rad_o  (srad[j+1])
    );
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      num[l] = {side_q[ST_D0-1].anrm[l], 30'b0} + 62'(sroot[SQRT_CELLS] >> 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag0_q <= sroot[SQRT_CELLS];
      for (int l = 0; l < 3; l++) begin
        rem0_q[l] <= {1'b0, num[l][61:31]};
        low0_q[l] <= num[l][30:0];
      end
    end
  end

  assign dmag[0] = mag0_q;
  assign drem[0] = rem0_q;
  assign dlow[0] = low0_q;
  assign dquo[0] = '0;

  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    rvau_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .mag_i (dmag[j]),
      .rem_i (drem[j]),
      .low_i (dlow[j]),
      .quo_i (dquo[j]),
      .mag_o (dmag[j+1]),
      .rem_o (drem[j+1]),
      .low_o (dlow[j+1]),
      .quo_o (dquo[j+1])
    );
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      kval[l] = side_q[ST_K-1].sgn[l] ? -word_t'({1'b0, dquo[DIV_CELLS][l]})
                                      :  word_t'({1'b0, dquo[DIV_CELLS][l]});
    end
    tsum  = {1'b0, side_q[ST_K-1].tang} + 17'h02000;
    quad  = tsum[15:14];
    dang  = side_q[ST_K-1].tang - {quad, 14'b0};
    zprod = dang * TWO_PI_Q30;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      z70_q <= cord_t'(rshr(wide_t'(zprod), 7'd16));
    end
  end

  assign cx[0] = INV_GAIN;
  assign cy[0] = '0;
  assign cz[0] = z70_q;

  for (genvar j = 0; j < CORDIC_N; j++) begin : g_cordic
    rvau_cordic_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .step_i (5'(j)),
      .x_i    (cx[j]),
      .y_i    (cy[j]),
      .z_i    (cz[j]),
      .x_o    (cx[j+1]),
      .y_o    (cy[j+1]),
      .z_o    (cz[j+1])
    );
  end

  always_comb begin
    case (side_q[ST_B1-1].quad)
      2'd0: begin
        cr_c = cx[CORDIC_N];
        cr_s = cy[CORDIC_N];
      end
      2'd1: begin
        cr_c = -cy[CORDIC_N];
        cr_s = cx[CORDIC_N];
      end
      2'd2: begin
        cr_c = -cx[CORDIC_N];
        cr_s = -cy[CORDIC_N];
      end
      default: begin
        cr_c = cy[CORDIC_N];
        cr_s = -cx[CORDIC_N];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= clamp_q30(cr_c);
      s_q <= clamp_q30(cr_s);
    end
  end

  rvau_combine u_combine (
    .clk_i  (clk_i),
    .en_i   (en),
    .k_i    (side_q[ST_B1].k),
    .vec_i  (side_q[ST_B1].vec),
    .cos_i  (c_q),
    .sin_i  (s_q),
    .zero_i (side_q[ST_B1].zero),
    .out_o  (res),
    .zero_o (res_zero),
    .sat_o  (res_sat)
  );

  assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];
  assign m_axis_tdata  = {res[2], res[1], res[0]};
  assign m_axis_tuser  = {res_sat, res_zero};

endmodule

FILE: rtl/rvau_checker.sv
// Port-level checks of the rotation unit, attached to the top level by bind.
// Depends only on the ports of rotate_vector_about_axis_unit.
module rvau_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while the pipeline is stalled");

  a_zero_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0 && !m_axis_tuser[1])
    else $error("zero axis result is not clean");

  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      m_axis_tdata[31:0] == 32'h7FFFFFFF || m_axis_tdata[31:0] == 32'h80000000 ||
      m_axis_tdata[63:32] == 32'h7FFFFFFF || m_axis_tdata[63:32] == 32'h80000000 ||
      m_axis_tdata[95:64] == 32'h7FFFFFFF || m_axis_tdata[95:64] == 32'h80000000)
    else $error("saturation flagged without a clamped component");

endmodule

bind rotate_vector_about_axis_unit rvau_checker u_rvau_checker (.*);

FILE: bench/tb_top.sv
// Self-checking bench for rotate_vector_about_axis_unit: a built-in predictor of the
// axis-angle rotation checks every result, with random idling on both stream sides in most tests.
// Depends on rvau_pkg and the RTL of the block.
`timescale 1ns / 100ps
module tb_top;
  import rvau_pkg::*;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic zero_axis, saturated;
  } rot_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [207:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  rot_result_t  rot_expected_q[$];
  int           n_errors;
  int           n_results;
  int           n_sent;
  bit           idle_allowed;

  rotate_vector_about_axis_unit DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("FAIL rotate_vector_about_axis_unit");
    $finish;
  end

  function automatic longint round_shift(longint v, int n);
    longint h;
    h = longint'(1) << (n - 1);
    if (v >= 0) return (v + h) >>> n;
    return -((-v + h) >>> n);
  endfunction

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint arctan_entry(int i);
    longint tab[30] = '{
      'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76,
      'h01FFD55B, 'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD,
      'h000FFFFF, 'h0007FFFF, 'h0003FFFF, 'h0001FFFF, 'h0000FFFF,
      'h00007FFF, 'h00003FFF, 'h00001FFF, 'h00000FFF, 'h000007FF,
      'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F, 'h0000003F,
      'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002};
    return tab[i];
  endfunction

  task automatic angle_to_cos_sin(input logic [15:0] t, output longint c, output longint s);
    logic [1:0]  quad;
    logic [15:0] resid;
    longint d, x, y, z, nx, cc, ss;
    quad = 2'((t + 17'h2000) >> 14);
    resid = t - {quad, 14'd0};
    d = longint'($signed(resid));
    z = round_shift(d * 64'sd6746518852, 16);
    x = 64'sh26DD3B6A;
    y = 0;
    for (int i = 0; i < CORDIC_N; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z = z - arctan_entry(i);
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z = z + arctan_entry(i);
      end
      x = nx;
    end
    case (quad)
      2'd0: begin cc = x; ss = y; end
      2'd1: begin cc = -y; ss = x; end
      2'd2: begin cc = -x; ss = -y; end
      default: begin cc = y; ss = -x; end
    endcase
    c = clamp_unit(cc);
    s = clamp_unit(ss);
  endtask

  task automatic predict_rotation(input logic [207:0] req, output rot_result_t r);
    longint v[3], a[3], k[3], cr[3], sum[3], res[3];
    longint c, s, p, pc, mag, num, qv;
    longint unsigned big, m2;
    r.zero_axis = 1'b0;
    r.saturated = 1'b0;
    big = 0;
    m2 = 0;
    for (int i = 0; i < 3; i++) begin
      v[i] = longint'($signed(req[32*i +: 32]));
      a[i] = longint'($signed(req[96 + 32*i +: 32]));
      if (longint'(a[i] < 0 ? -a[i] : a[i]) > longint'(big))
        big = a[i] < 0 ? -a[i] : a[i];
    end
    if (big == 0) begin
      r.x = 0; r.y = 0; r.z = 0;
      r.zero_axis = 1'b1;
      return;
    end
    while (big < (64'd1 << 30)) begin
      big = big << 1;
      for (int i = 0; i < 3; i++) a[i] = a[i] * 2;
    end
    for (int i = 0; i < 3; i++) m2 = m2 + longint'(a[i] * a[i]);
    mag = longint'(int_sqrt(m2));
    for (int i = 0; i < 3; i++) begin
      num = (a[i] < 0 ? -a[i] : a[i]) * 64'sd1073741824;
      qv = (num + mag / 2) / mag;
      k[i] = a[i] < 0 ? -qv : qv;
    end
    angle_to_cos_sin(req[207:192], c, s);
    p = round_shift(k[0]*v[0] + k[1]*v[1] + k[2]*v[2], 30);
    cr[0] = round_shift(k[1]*v[2] - k[2]*v[1], 30);
    cr[1] = round_shift(k[2]*v[0] - k[0]*v[2], 30);
    cr[2] = round_shift(k[0]*v[1] - k[1]*v[0], 30);
    pc = round_shift(p * (64'sd1073741824 - c), 30);
    for (int i = 0; i < 3; i++) begin
      sum[i] = round_shift(v[i]*c, 30) + round_shift(cr[i]*s, 30) + round_shift(k[i]*pc, 30);
      res[i] = sum[i];
      if (sum[i] > 64'sd2147483647) begin
        res[i] = 64'sd2147483647;
        r.saturated = 1'b1;
      end else if (sum[i] < -64'sd2147483648) begin
        res[i] = -64'sd2147483648;
        r.saturated = 1'b1;
      end
    end
    r.x = res[0][31:0];
    r.y = res[1][31:0];
    r.z = res[2][31:0];
  endtask

  task automatic send_rotation(input logic [31:0] vx, vy, vz, ax, ay, az, input logic [15:0] ang);
    logic [207:0] req;
    rot_result_t exp_r;
    int gap;
    req = {ang, az, ay, ax, vz, vy, vx};
    if (idle_allowed && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    predict_rotation(req, exp_r);
    rot_expected_q.push_back(exp_r);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic finish_requests();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 255) - 128;
      1: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] one;
    one = 32'h0001_0000;
    send_rotation(one, 0, 0, 0, 0, one, 16'h4000);
    send_rotation(one, one, one, 0, 0, 0, 16'h1234);
    send_rotation(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1, 1, 0, 16'h2000);
    send_rotation(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 16'h0000);
    send_rotation(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                  32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF);
    send_rotation(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h80000000, 16'h8000);
    send_rotation(one, 2*one, 3*one, 0, 32'hFFFFFFFF, 0, 16'hC000);
    send_rotation(32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 3, 4, 5, 16'h1FFF);
    send_rotation(32'h7FFFFFFF, 0, 0, 0, 32'h80000000, 0, 16'h6000);
    send_rotation(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, one, 16'h2000);
    send_rotation(one, 0, 0, one, one, one, 16'h5555);
    send_rotation(32'hFFFFFFFF, 1, 32'hFFFF0000, 0, 0, 0, 16'hFFFF);
  endtask

  task automatic test_random(input int count);
    logic [31:0] a0, a1, a2;
    for (int i = 0; i < count; i++) begin
      a0 = random_word();
      a1 = random_word();
      a2 = random_word();
      if ($urandom_range(0, 40) == 0) begin
        a0 = 0; a1 = 0; a2 = 0;
      end
      send_rotation(random_word(), random_word(), random_word(), a0, a1, a2,
                    16'($urandom));
    end
  endtask

  task automatic drain_results();
    finish_requests();
    while (rot_expected_q.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  // Sink side: random stalls, then compare each accepted result with the oldest prediction.
  initial begin
    rot_result_t e;
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (idle_allowed && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 7);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (rot_expected_q.size() == 0) begin
          $display("%0t: unexpected result %h / %b", $time, m_axis_tdata, m_axis_tuser);
          n_errors++;
        end else begin
          e = rot_expected_q.pop_front();
          if ({e.z, e.y, e.x} !== m_axis_tdata || {e.saturated, e.zero_axis} !== m_axis_tuser)
          begin
            $display("%0t: expected xyz %h %h %h flags %b%b, got %h %h %h flags %b",
                     $time, e.x, e.y, e.z, e.zero_axis, e.saturated,
                     m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                     {m_axis_tuser[0], m_axis_tuser[1]});
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    n_errors = 0;
    n_results = 0;
    n_sent = 0;
    idle_allowed = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(1700);
    idle_allowed = 1'b0;
    test_random(300);
    drain_results();
    $display("Sent %0d rotation requests, %0d results checked, including zero axes,",
             n_sent, n_results);
    $display("saturating extremes and all angle quadrants.");
    if (n_errors == 0) begin
      $display("PASS rotate_vector_about_axis_unit");
    end else begin
      $display("FAIL rotate_vector_about_axis_unit");
    end
    $finish;
  end

endmodule
